>>> design/gfinv_pkg.sv
// Shared types and constants for the GF(2) polynomial inverse block.
package gfinv_pkg;

    // Default field degree and the modulus after reset (x^8+x^4+x^3+x+1)
    localparam int FIELD_DEGREE_DEF = 8;
    localparam int MODULUS_RESET    = 283;

    // Sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Operation of the shared shift-and-XOR unit in one cycle
    typedef enum logic [2:0] {
        STEP_HOLD,
        STEP_DONE,
        STEP_DEC_CUR,
        STEP_DEC_PREV,
        STEP_REDUCE,
        STEP_SWAP
    } t_step;

endpackage

>>> design/gf2_poly_inverse_ext_euclid.sv
// Top level: iterative extended Euclidean inverse of a binary polynomial.
//
// Usage:
//   Input channel  (i_in_valid / o_in_ready) moves one word: i_operand_poly.
//   Output channel (o_out_valid / i_out_ready) moves one word: o_inverse_poly,
//   o_operand_zero and o_gcd_not_one. The user writes the modulus through
//   i_cfg_wr_en / i_cfg_wr_data while the block is idle; it is not checked.
//   After a word is accepted, one shared shift-and-XOR unit runs one step per
//   cycle, unless it holds for a full output register: a degree decrement of
//   either remainder, one division step (r_prev ^= r_cur << shift, with the
//   same shift applied to the Bezout coefficients), or a swap of the pair.
//   A zero operand needs no step; the result enters the output register in
//   the cycle after the unit finishes. One item is in work at a time;
//   o_in_ready is high only while the unit is idle.
//   The finished result sits in an output register; a new word may be taken
//   while it waits. If the receiver stalls, the next result holds in the
//   unit until the output register frees up.
//   Reset (i_rst_n low, synchronous) empties the unit and the output register
//   and loads the modulus x^8+x^4+x^3+x+1, cut to FIELD_DEGREE+1 bits.
module gf2_poly_inverse_ext_euclid #(
    parameter int FIELD_DEGREE = gfinv_pkg::FIELD_DEGREE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_wr_en,
    input  logic [FIELD_DEGREE:0]   i_cfg_wr_data,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FIELD_DEGREE-1:0] i_operand_poly,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [FIELD_DEGREE-1:0] o_inverse_poly,
    output logic                    o_operand_zero,
    output logic                    o_gcd_not_one
);

    localparam int DW = $clog2(FIELD_DEGREE + 1);
    localparam logic [63:0] MOD_RST64 = 64'(gfinv_pkg::MODULUS_RESET);
    localparam logic [FIELD_DEGREE:0] MOD_RST = MOD_RST64[FIELD_DEGREE:0];
    localparam logic [DW-1:0] DEG_PREV_INIT = DW'(FIELD_DEGREE);
    localparam logic [DW-1:0] DEG_CUR_INIT  = DW'(FIELD_DEGREE - 1);

    // Registers
    gfinv_pkg::t_state        r_state, n_state;
    logic [FIELD_DEGREE:0]    r_modulus_poly;
    logic [FIELD_DEGREE:0]    r_rem_prev, n_rem_prev;
    logic [FIELD_DEGREE:0]    r_rem_cur, n_rem_cur;
    logic [DW-1:0]            r_deg_prev, n_deg_prev;
    logic [DW-1:0]            r_deg_cur, n_deg_cur;
    logic [FIELD_DEGREE-1:0]  r_coef_prev, n_coef_prev;
    logic [FIELD_DEGREE-1:0]  r_coef_cur, n_coef_cur;
    logic                     r_zero;
    logic                     r_out_valid;
    logic [FIELD_DEGREE-1:0]  r_out_inv;
    logic                     r_out_zero;
    logic                     r_out_gcd;

    gfinv_pkg::t_step         step;
    logic                     in_accept;
    logic                     out_free;
    logic [DW-1:0]            shift;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign shift     = r_deg_prev - r_deg_cur;

    // Pick the operation of the shared unit for this cycle
    always_comb begin
        step = gfinv_pkg::STEP_HOLD;
        if (r_state == gfinv_pkg::ST_RUN) begin
            priority if (r_rem_cur == '0) begin
                step = out_free ? gfinv_pkg::STEP_DONE : gfinv_pkg::STEP_HOLD;
            end else if (!r_rem_cur[r_deg_cur]) begin
                step = gfinv_pkg::STEP_DEC_CUR;
            end else if (r_rem_prev == '0) begin
                step = gfinv_pkg::STEP_SWAP;
            end else if (!r_rem_prev[r_deg_prev]) begin
                step = gfinv_pkg::STEP_DEC_PREV;
            end else if (r_deg_prev >= r_deg_cur) begin
                step = gfinv_pkg::STEP_REDUCE;
            end else begin
                step = gfinv_pkg::STEP_SWAP;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gfinv_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = gfinv_pkg::ST_RUN;
                end
            end
            gfinv_pkg::ST_RUN: begin
                if (step == gfinv_pkg::STEP_DONE) begin
                    n_state = gfinv_pkg::ST_IDLE;
                end
            end
            default: n_state = gfinv_pkg::ST_IDLE;
        endcase
    end

    // Datapath update: load, decrement, reduce or swap
    always_comb begin
        n_rem_prev  = r_rem_prev;
        n_rem_cur   = r_rem_cur;
        n_deg_prev  = r_deg_prev;
        n_deg_cur   = r_deg_cur;
        n_coef_prev = r_coef_prev;
        n_coef_cur  = r_coef_cur;
        if (in_accept) begin
            n_rem_prev  = r_modulus_poly;
            n_rem_cur   = {1'b0, i_operand_poly};
            n_deg_prev  = DEG_PREV_INIT;
            n_deg_cur   = DEG_CUR_INIT;
            n_coef_prev = '0;
            n_coef_cur  = FIELD_DEGREE'(1);
        end else begin
            unique case (step)
                gfinv_pkg::STEP_DEC_CUR:  n_deg_cur  = r_deg_cur - 1'b1;
                gfinv_pkg::STEP_DEC_PREV: n_deg_prev = r_deg_prev - 1'b1;
                gfinv_pkg::STEP_REDUCE: begin
                    n_rem_prev  = r_rem_prev ^ (r_rem_cur << shift);
                    n_coef_prev = r_coef_prev ^ (r_coef_cur << shift);
                end
                gfinv_pkg::STEP_SWAP: begin
                    n_rem_prev  = r_rem_cur;
                    n_rem_cur   = r_rem_prev;
                    n_deg_prev  = r_deg_cur;
                    n_deg_cur   = r_deg_prev;
                    n_coef_prev = r_coef_cur;
                    n_coef_cur  = r_coef_prev;
                end
                gfinv_pkg::STEP_HOLD, gfinv_pkg::STEP_DONE: ;
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= gfinv_pkg::ST_IDLE;
            r_modulus_poly <= MOD_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_modulus_poly <= i_cfg_wr_data;
            end
            if (step == gfinv_pkg::STEP_DONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output word
    always_ff @(posedge i_clk) begin
        r_rem_prev  <= n_rem_prev;
        r_rem_cur   <= n_rem_cur;
        r_deg_prev  <= n_deg_prev;
        r_deg_cur   <= n_deg_cur;
        r_coef_prev <= n_coef_prev;
        r_coef_cur  <= n_coef_cur;
        if (in_accept) begin
            r_zero <= (i_operand_poly == '0);
        end
        if (step == gfinv_pkg::STEP_DONE) begin
            r_out_inv  <= r_zero ? FIELD_DEGREE'(1) : r_coef_prev;
            r_out_zero <= r_zero;
            r_out_gcd  <= (r_rem_prev != (FIELD_DEGREE + 1)'(1));
        end
    end

    assign o_in_ready     = (r_state == gfinv_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_inverse_poly = r_out_inv;
    assign o_operand_zero = r_out_zero;
    assign o_gcd_not_one  = r_out_gcd;

    // Remainders carry no bits above their tracked degrees
    a_cur_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gfinv_pkg::ST_RUN) |-> (((r_rem_cur >> r_deg_cur) >> 1) == '0))
        else $error("r_rem_cur has bits above r_deg_cur");

    a_prev_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gfinv_pkg::ST_RUN) |-> (((r_rem_prev >> r_deg_prev) >> 1) == '0))
        else $error("r_rem_prev has bits above r_deg_prev");

    // A division step clears the leading term of the dividend
    a_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step == gfinv_pkg::STEP_REDUCE) |=> !r_rem_prev[$past(r_deg_prev)])
        else $error("division step left leading term set");

    // A finished item lands in the output register
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step == gfinv_pkg::STEP_DONE) |=> (o_out_valid && o_in_ready))
        else $error("finished item not presented");

    // An accepted word starts the sequencer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == gfinv_pkg::ST_RUN))
        else $error("accepted word did not start the unit");

endmodule
